@@ rtl/mmd_pkg.sv @@
// ----------------------------------------------------------------------------
// mmd_pkg: shared types and constants for the MIDI message decoder
// Request and result item layouts, result kinds and sizing defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package mmd_pkg;

  localparam int UNIVERSAL_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [4:0] KIND_CC        = 5'd3;
  localparam logic [4:0] KIND_SYSEX_DAT = 5'd7;
  localparam logic [4:0] KIND_SYSEX_END = 5'd8;
  localparam logic [4:0] KIND_QFRAME    = 5'd9;
  localparam logic [4:0] KIND_SONGPOS   = 5'd10;
  localparam logic [4:0] KIND_SONGSEL   = 5'd11;
  localparam logic [4:0] KIND_TUNE      = 5'd12;
  localparam logic [4:0] KIND_CLOCK     = 5'd13;
  localparam logic [4:0] KIND_START     = 5'd14;
  localparam logic [4:0] KIND_CONT      = 5'd15;
  localparam logic [4:0] KIND_STOP      = 5'd16;
  localparam logic [4:0] KIND_SENSE     = 5'd17;
  localparam logic [4:0] KIND_RESET     = 5'd18;
  localparam logic [4:0] KIND_CHANMODE  = 5'd19;
  localparam logic [4:0] KIND_IDREQ     = 5'd27;
  localparam logic [4:0] KIND_IDREPLY   = 5'd28;
  localparam logic [4:0] KIND_MTCFULL   = 5'd29;
  localparam logic [4:0] KIND_OTHERUNIV = 5'd30;
  localparam logic [4:0] KIND_ERROR     = 5'd31;

  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_EOX     = 8'hF7;
  localparam logic [6:0] ID_UNIV_NRT = 7'h7E;
  localparam logic [6:0] ID_UNIV_RT  = 7'h7F;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        packet_last;
    logic [31:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [6:0]  channel;
    logic [6:0]  key_or_number;
    logic [13:0] value;
    logic [22:0] vendor_id;
    logic [13:0] detail_a;
    logic [13:0] detail_b;
    logic [13:0] detail_c;
    logic [13:0] detail_d;
    logic [6:0]  payload_byte;
    logic        local_on;
    logic [31:0] event_time;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/midi_message_decoder.sv @@
// ----------------------------------------------------------------------------
// midi_message_decoder: MIDI 1.0 byte stream to event decoder
// Parser front end feeding a result queue.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle whenever the result queue has room; a byte
// that finishes a message yields its event in the queue at the next edge, so
// decoding runs at one byte per clock with no per-message overhead. The
// two-entry result queue sets how long the consumer may stall before full
// rises. Universal sysex bytes are buffered up to UNIVERSAL_DEPTH entries
// (at most 31) and decoded when the closing F7 arrives.
`default_nettype none

module midi_message_decoder
  import mmd_pkg::*;
#(
  parameter int UNIVERSAL_DEPTH = UNIVERSAL_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  in_data,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_data
);

  logic      accept;
  logic      emit;
  out_item_t result;

  assign accept = push && !full;

  mmd_front #(.UNIVERSAL_DEPTH(UNIVERSAL_DEPTH)) u_front (
    .clk, .rst, .accept, .item(in_data), .cfg_we, .cfg_data,
    .emit, .result
  );

  mmd_queue u_queue (
    .clk, .rst, .wr(emit), .wr_data(result), .rd(pop),
    .full, .empty, .rd_data(out_data)
  );

endmodule

`default_nettype wire

@@ rtl/mmd_front.sv @@
// ----------------------------------------------------------------------------
// mmd_front: byte parser and event classifier
// Tracks status, data bytes and sysex state; builds one event per finished
// message, per plain sysex data byte and per error, and hands it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mmd_front
  import mmd_pkg::*;
#(
  parameter int UNIVERSAL_DEPTH = UNIVERSAL_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire in_item_t  item,
  input  wire logic      cfg_we,
  input  wire logic      cfg_data,
  output logic           emit,
  output out_item_t      result
);

  localparam int IW = $clog2(UNIVERSAL_DEPTH);
  localparam logic [4:0] CAP = 5'((UNIVERSAL_DEPTH < 31) ? UNIVERSAL_DEPTH : 31);

  typedef enum logic [2:0] {
    PH_IDLE, PH_DATA, PH_SXID, PH_SXEXT, PH_SXDATA, PH_UNIV
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  status_held, status_held_next;
  logic [4:0]  data_count, data_count_next;
  logic [6:0]  first_data, first_data_next;
  logic [20:0] sysex_id, sysex_id_next;
  logic [31:0] latched_time, latched_time_next;
  logic        promote;
  logic [6:0]  ubuf [UNIVERSAL_DEPTH];
  logic        ub_we;
  logic [6:0]  bv [14];

  // Expose the first buffer entries at fixed places; missing ones read zero
  for (genvar i = 0; i < 14; i++) begin : g_view
    if (i < UNIVERSAL_DEPTH) begin : g_have
      assign bv[i] = ubuf[i];
    end else begin : g_none
      assign bv[i] = 7'd0;
    end
  end

  // Short channel and system common message decode
  function automatic out_item_t decode_short(logic [7:0] st, logic [6:0] d1,
                                             logic [6:0] d2, logic prom,
                                             logic [31:0] t);
    out_item_t r;
    logic [2:0] grp;
    r = '0;
    grp = st[6:4];
    r.event_time = t;
    if (grp != 3'd7) begin
      r.kind = {2'b00, grp};
      r.channel = {3'b000, st[3:0]};
      r.key_or_number = d1;
      if (grp == 3'd1 || grp == 3'd2 || grp == 3'd3) begin
        r.value = {7'd0, d2};
      end else if (grp == 3'd5) begin
        r.key_or_number = '0;
        r.value = {7'd0, d1};
      end else if (grp == 3'd6) begin
        r.key_or_number = '0;
        r.value = {d2, d1};
      end
      if (grp == 3'd3 && prom && d1 >= 7'd120) begin
        r.kind = KIND_CHANMODE + {2'b00, d1[2:0]};
        r.key_or_number = (d1 == 7'd126) ? d2 : 7'd0;
        r.value = '0;
        r.local_on = (d1 == 7'd122 && d2 == 7'h7F);
      end
    end else if (st == 8'hF1) begin
      r.kind = KIND_QFRAME;
      r.key_or_number = {4'd0, d1[6:4]};
      r.value = {10'd0, d1[3:0]};
    end else if (st == 8'hF2) begin
      r.kind = KIND_SONGPOS;
      r.value = {d2, d1};
    end else begin
      r.kind = KIND_SONGSEL;
      r.key_or_number = d1;
    end
    return r;
  endfunction

  logic [7:0]  b;
  logic        last, is_status, two_data;
  logic [31:0] t;
  logic [22:0] vendor;
  out_item_t   univ;

  assign b = item.byte_value;
  assign last = item.packet_last;
  assign t = item.arrival_time;
  assign is_status = b[7];
  assign two_data = !(status_held[7:4] == 4'hC || status_held[7:4] == 4'hD ||
                      status_held == 8'hF1 || status_held == 8'hF3);
  assign vendor = {sysex_id[20:14], 1'b0, sysex_id[13:7], 1'b0, sysex_id[6:0]};

  // Decode a buffered universal sysex
  always_comb begin
    univ = '0;
    univ.kind = KIND_OTHERUNIV;
    univ.event_time = latched_time;
    univ.vendor_id = vendor;
    if (data_count >= 5'd1) univ.channel = bv[0];
    if (sysex_id[20:14] == ID_UNIV_NRT && data_count >= 5'd3 &&
        bv[1] == 7'd6 && bv[2] == 7'd1) begin
      univ.kind = KIND_IDREQ;
    end else if (sysex_id[20:14] == ID_UNIV_NRT && data_count >= 5'd4 &&
                 bv[1] == 7'd6 && bv[2] == 7'd2) begin
      if (bv[3] == 7'd0) begin
        if (data_count >= 5'd14) begin
          univ.kind = KIND_IDREPLY;
          univ.vendor_id = {8'd0, bv[4][6:0], 1'b0, bv[5]};
          univ.detail_a = {bv[7], bv[6]};
          univ.detail_b = {bv[9], bv[8]};
          univ.detail_c = {bv[11], bv[10]};
          univ.detail_d = {bv[13], bv[12]};
        end
      end else if (data_count >= 5'd12) begin
        univ.kind = KIND_IDREPLY;
        univ.vendor_id = {bv[3], 16'd0};
        univ.detail_a = {bv[5], bv[4]};
        univ.detail_b = {bv[7], bv[6]};
        univ.detail_c = {bv[9], bv[8]};
        univ.detail_d = {bv[11], bv[10]};
      end
    end else if (sysex_id[20:14] == ID_UNIV_RT && data_count >= 5'd7 &&
                 bv[1] == 7'd1 && bv[2] == 7'd1) begin
      univ.kind = KIND_MTCFULL;
      univ.detail_a = {7'd0, bv[3]};
      univ.detail_b = {7'd0, bv[4]};
      univ.detail_c = {7'd0, bv[5]};
      univ.detail_d = {7'd0, bv[6]};
    end
  end

  // Advance the parser for one accepted byte
  always_comb begin
    logic err;
    logic [31:0] err_t;
    err = 1'b0;
    err_t = latched_time;
    emit = 1'b0;
    result = '0;
    ub_we = 1'b0;
    phase_next = phase;
    status_held_next = status_held;
    data_count_next = data_count;
    first_data_next = first_data;
    sysex_id_next = sysex_id;
    latched_time_next = latched_time;
    case (phase)
      PH_IDLE: begin
        err_t = t;
        if (!is_status) begin
          err = 1'b1;
        end else begin
          latched_time_next = t;
          status_held_next = b;
          data_count_next = '0;
          if (b < 8'hF0 || b == 8'hF1 || b == 8'hF2 || b == 8'hF3) begin
            phase_next = PH_DATA;
            err = last;
          end else if (b == ST_SYSEX) begin
            phase_next = PH_SXID;
            err = last;
          end else begin
            emit = 1'b1;
            result.event_time = t;
            case (b)
              8'hF6: result.kind = KIND_TUNE;
              8'hF8: result.kind = KIND_CLOCK;
              8'hFA: result.kind = KIND_START;
              8'hFB: result.kind = KIND_CONT;
              8'hFC: result.kind = KIND_STOP;
              8'hFE: result.kind = KIND_SENSE;
              8'hFF: result.kind = KIND_RESET;
              default: err = 1'b1;
            endcase
          end
        end
      end
      PH_DATA: begin
        if (is_status) begin
          err = 1'b1;
        end else if (data_count == 5'd0 && two_data) begin
          first_data_next = b[6:0];
          data_count_next = 5'd1;
          err = last;
        end else begin
          phase_next = PH_IDLE;
          emit = 1'b1;
          result = two_data ?
                   decode_short(status_held, first_data, b[6:0], promote, latched_time) :
                   decode_short(status_held, b[6:0], 7'd0, promote, latched_time);
        end
      end
      PH_SXID: begin
        if (is_status) begin
          err = 1'b1;
        end else begin
          sysex_id_next = {b[6:0], 14'd0};
          data_count_next = '0;
          if (b[6:0] == 7'd0) phase_next = PH_SXEXT;
          else if (b[6:0] == ID_UNIV_NRT || b[6:0] == ID_UNIV_RT) phase_next = PH_UNIV;
          else phase_next = PH_SXDATA;
          err = last;
        end
      end
      PH_SXEXT: begin
        if (is_status) begin
          err = 1'b1;
        end else begin
          if (data_count == 5'd0) begin
            sysex_id_next[13:7] = b[6:0];
            data_count_next = 5'd1;
          end else begin
            sysex_id_next[6:0] = b[6:0];
            phase_next = PH_SXDATA;
          end
          err = last;
        end
      end
      PH_SXDATA: begin
        if (b == ST_EOX) begin
          phase_next = PH_IDLE;
          emit = 1'b1;
          result.kind = KIND_SYSEX_END;
          result.vendor_id = vendor;
          result.event_time = latched_time;
        end else if (is_status || last) begin
          err = 1'b1;
        end else begin
          emit = 1'b1;
          result.kind = KIND_SYSEX_DAT;
          result.vendor_id = vendor;
          result.payload_byte = b[6:0];
          result.event_time = latched_time;
        end
      end
      PH_UNIV: begin
        if (b == ST_EOX) begin
          phase_next = PH_IDLE;
          emit = 1'b1;
          result = univ;
        end else if (is_status) begin
          err = 1'b1;
        end else begin
          if (data_count < CAP) begin
            ub_we = 1'b1;
            data_count_next = data_count + 5'd1;
          end
          err = last;
        end
      end
      default: begin
        err = 1'b1;
        err_t = t;
      end
    endcase
    // Replace any result with an error and drop back to idle
    if (err) begin
      phase_next = PH_IDLE;
      emit = 1'b1;
      result = '0;
      result.kind = KIND_ERROR;
      result.event_time = err_t;
    end
    emit = emit && accept;
  end

  // Hold parser state and the configuration bit
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      status_held <= '0;
      data_count <= '0;
      first_data <= '0;
      sysex_id <= '0;
      latched_time <= '0;
      promote <= 1'b1;
    end else begin
      if (cfg_we) promote <= cfg_data;
      if (accept) begin
        phase <= phase_next;
        status_held <= status_held_next;
        data_count <= data_count_next;
        first_data <= first_data_next;
        sysex_id <= sysex_id_next;
        latched_time <= latched_time_next;
      end
    end
  end

  // Store universal sysex bytes
  always_ff @(posedge clk) begin
    if (accept && ub_we) ubuf[data_count[IW-1:0]] <= b[6:0];
  end

endmodule

`default_nettype wire

@@ rtl/mmd_queue.sv @@
// ----------------------------------------------------------------------------
// mmd_queue: result queue
// Short queue of decoded events between parser and consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module mmd_queue
  import mmd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr,
  input  wire out_item_t wr_data,
  input  wire logic      rd,
  output logic           full,
  output logic           empty,
  output out_item_t      rd_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  out_item_t        mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [PW:0]      count;
  logic             do_rd;

  assign full = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_rd = rd && !empty;
  assign rd_data = mem[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(wr) - (PW+1)'(do_rd);
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

@@ rtl/mmd_checker.sv @@
// ----------------------------------------------------------------------------
// mmd_checker: port-level checks for the MIDI message decoder
// Queue flag consistency and result hold behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module mmd_checker
  import mmd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_data
);

  // Come out of reset with nothing queued
  a_reset: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue not clear after reset");

  // Never full and empty at once
  a_flags: assert property (@(posedge clk) disable iff (rst) !(full && empty))
    else $error("full and empty together");

  // Keep a waiting result present
  a_keep: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result lost");

  // Hold a waiting result steady
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(out_data))
    else $error("waiting result changed");

endmodule

bind midi_message_decoder mmd_checker u_checker (
  .clk, .rst, .full, .empty, .pop, .out_data
);

`default_nettype wire

@@ tb/midi_event_checker.sv @@
// ----------------------------------------------------------------------------
// midi_event_checker: decoded event predictor and scoreboard
// Watches the byte and event queues of the MIDI decoder, predicts each event
// from the accepted bytes and compares every field of the events it sees.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_event_checker
  import mmd_pkg::*;
#(
  parameter int UNIVERSAL_DEPTH = UNIVERSAL_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire logic      full,
  input  wire in_item_t  in_data,
  input  wire logic      empty,
  input  wire logic      pop,
  input  wire out_item_t out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_data,
  output int             fail_count,
  output int             pending_events,
  output int             event_count
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_DATA, PH_SXID, PH_SXEXT, PH_SXDATA, PH_UNIV
  } phase_t;

  localparam logic [4:0] KIND_BEND    = 5'd6;
  localparam logic [4:0] KIND_CHANAT  = 5'd5;
  localparam logic [6:0] CC_MODE_BASE = 7'd120;
  localparam logic [6:0] CC_LOCAL     = 7'd122;
  localparam logic [6:0] CC_MONO      = 7'd126;

  logic       promote;
  phase_t     phase;
  logic [7:0] status_q;
  int         count_q;
  logic [6:0] first_q;
  logic [6:0] id0, id1, id2;
  logic [6:0] ubuf [UNIVERSAL_DEPTH];
  logic [31:0] time_q;

  out_item_t expected_events[$];

  function automatic out_item_t blank_event(logic [4:0] k, logic [31:0] t);
    out_item_t e;
    e = '0;
    e.kind = k;
    e.event_time = t;
    return e;
  endfunction

  function automatic logic [22:0] sysex_vendor();
    return {id0, 1'b0, id1, 1'b0, id2} & 23'h7F7F7F;
  endfunction

  function automatic int needed_bytes(logic [7:0] st);
    if (st[7:4] == 4'hC || st[7:4] == 4'hD || st == 8'hF1 || st == 8'hF3) return 1;
    return 2;
  endfunction

  function automatic logic [13:0] pair14(int i);
    return {ubuf[i + 1], ubuf[i]};
  endfunction

  function automatic out_item_t short_event(logic [6:0] d1, logic [6:0] d2);
    out_item_t e;
    logic [2:0] grp;
    e = blank_event(5'd0, time_q);
    grp = status_q[6:4];
    if (grp != 3'd7) begin
      e.kind = {2'b00, grp};
      e.channel = {3'b000, status_q[3:0]};
      e.key_or_number = d1;
      if (grp == 3'd1 || grp == 3'd2 || grp == 3'd3) e.value = {7'd0, d2};
      else if (e.kind == KIND_CHANAT) begin
        e.key_or_number = '0;
        e.value = {7'd0, d1};
      end else if (e.kind == KIND_BEND) begin
        e.key_or_number = '0;
        e.value = {d2, d1};
      end
      if (e.kind == KIND_CC && promote && d1 >= CC_MODE_BASE) begin
        e.kind = KIND_CHANMODE + 5'(d1 - CC_MODE_BASE);
        e.key_or_number = (d1 == CC_MONO) ? d2 : 7'd0;
        e.value = '0;
        e.local_on = (d1 == CC_LOCAL && d2 == 7'h7F);
      end
    end else if (status_q == 8'hF1) begin
      e.kind = KIND_QFRAME;
      e.key_or_number = {4'd0, d1[6:4]};
      e.value = {10'd0, d1[3:0]};
    end else if (status_q == 8'hF2) begin
      e.kind = KIND_SONGPOS;
      e.value = {d2, d1};
    end else begin
      e.kind = KIND_SONGSEL;
      e.key_or_number = d1;
    end
    return e;
  endfunction

  function automatic out_item_t universal_event();
    out_item_t e;
    int n, off, need;
    n = count_q;
    e = blank_event(KIND_OTHERUNIV, time_q);
    e.vendor_id = sysex_vendor();
    if (n >= 1) e.channel = ubuf[0];
    if (id0 == ID_UNIV_NRT && n >= 3 && ubuf[1] == 7'd6 && ubuf[2] == 7'd1) begin
      e.kind = KIND_IDREQ;
    end else if (id0 == ID_UNIV_NRT && n >= 4 && ubuf[1] == 7'd6 && ubuf[2] == 7'd2) begin
      need = (ubuf[3] == 0) ? 14 : 12;
      off = (ubuf[3] == 0) ? 6 : 4;
      if (n >= need) begin
        e.kind = KIND_IDREPLY;
        e.vendor_id = (ubuf[3] == 0) ? {8'd0, ubuf[4], 1'b0, ubuf[5]}
                                     : {ubuf[3], 16'd0};
        e.detail_a = pair14(off);
        e.detail_b = pair14(off + 2);
        e.detail_c = pair14(off + 4);
        e.detail_d = pair14(off + 6);
      end
    end else if (id0 == ID_UNIV_RT && n >= 7 && ubuf[1] == 7'd1 && ubuf[2] == 7'd1) begin
      e.kind = KIND_MTCFULL;
      e.detail_a = {7'd0, ubuf[3]};
      e.detail_b = {7'd0, ubuf[4]};
      e.detail_c = {7'd0, ubuf[5]};
      e.detail_d = {7'd0, ubuf[6]};
    end
    return e;
  endfunction

  // Advance the predictor by one accepted byte; return 1 with an event.
  function automatic bit decode_byte(in_item_t r, output out_item_t e);
    logic [7:0] b;
    bit st, last;
    b = r.byte_value;
    st = b[7];
    last = r.packet_last;
    e = blank_event(KIND_ERROR, time_q);
    case (phase)
      PH_IDLE: begin
        e.event_time = r.arrival_time;
        if (!st) return 1;
        time_q = r.arrival_time;
        status_q = b;
        count_q = 0;
        if (b < ST_SYSEX || b == 8'hF1 || b == 8'hF2 || b == 8'hF3) begin
          phase = PH_DATA;
          if (last) phase = PH_IDLE;
          return last;
        end
        if (b == ST_SYSEX) begin
          phase = PH_SXID;
          if (last) phase = PH_IDLE;
          return last;
        end
        case (b)
          8'hF6: e.kind = KIND_TUNE;
          8'hF8: e.kind = KIND_CLOCK;
          8'hFA: e.kind = KIND_START;
          8'hFB: e.kind = KIND_CONT;
          8'hFC: e.kind = KIND_STOP;
          8'hFE: e.kind = KIND_SENSE;
          8'hFF: e.kind = KIND_RESET;
          default: e.kind = KIND_ERROR;
        endcase
        return 1;
      end
      PH_DATA: begin
        if (st) begin
          phase = PH_IDLE;
          return 1;
        end
        if (count_q == 0 && needed_bytes(status_q) == 2) begin
          first_q = b[6:0];
          count_q = 1;
          if (last) phase = PH_IDLE;
          return last;
        end
        phase = PH_IDLE;
        if (needed_bytes(status_q) == 2) e = short_event(first_q, b[6:0]);
        else e = short_event(b[6:0], 7'd0);
        return 1;
      end
      PH_SXID: begin
        if (st) begin
          phase = PH_IDLE;
          return 1;
        end
        id0 = b[6:0];
        id1 = '0;
        id2 = '0;
        count_q = 0;
        if (b == 0) phase = PH_SXEXT;
        else if (b[6:0] == ID_UNIV_NRT || b[6:0] == ID_UNIV_RT) phase = PH_UNIV;
        else phase = PH_SXDATA;
        if (last) phase = PH_IDLE;
        return last;
      end
      PH_SXEXT: begin
        if (st) begin
          phase = PH_IDLE;
          return 1;
        end
        if (count_q == 0) begin
          id1 = b[6:0];
          count_q = 1;
        end else begin
          id2 = b[6:0];
          phase = PH_SXDATA;
        end
        if (last) phase = PH_IDLE;
        return last;
      end
      PH_SXDATA: begin
        if (b == ST_EOX) begin
          phase = PH_IDLE;
          e.kind = KIND_SYSEX_END;
          e.vendor_id = sysex_vendor();
          return 1;
        end
        if (st || last) begin
          phase = PH_IDLE;
          return 1;
        end
        e.kind = KIND_SYSEX_DAT;
        e.vendor_id = sysex_vendor();
        e.payload_byte = b[6:0];
        return 1;
      end
      PH_UNIV: begin
        if (b == ST_EOX) begin
          phase = PH_IDLE;
          e = universal_event();
          return 1;
        end
        if (st) begin
          phase = PH_IDLE;
          return 1;
        end
        if (count_q < UNIVERSAL_DEPTH && count_q < 31) begin
          ubuf[count_q] = b[6:0];
          count_q++;
        end
        if (last) phase = PH_IDLE;
        return last;
      end
      default: begin
        phase = PH_IDLE;
        e.event_time = r.arrival_time;
        return 1;
      end
    endcase
  endfunction

  assign pending_events = expected_events.size();

  // Track requests and events at each edge; compare in acceptance order.
  always @(posedge clk) begin
    out_item_t e, want;
    if (rst) begin
      promote = 1'b1;
      phase = PH_IDLE;
      status_q = '0;
      count_q = 0;
      first_q = '0;
      id0 = '0;
      id1 = '0;
      id2 = '0;
      time_q = '0;
      fail_count <= 0;
      event_count <= 0;
      expected_events.delete();
    end else begin
      if (cfg_we) promote = cfg_data;
      if (pop && !empty) begin
        event_count <= event_count + 1;
        if (expected_events.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected event %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_events.pop_front();
          if (out_data !== want) begin
            if (fail_count < 10) begin
              $display("ERROR: event mismatch");
              $display("  expected %p", want);
              $display("  actual   %p", out_data);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (push && !full) begin
        if (decode_byte(in_data, e)) expected_events.push_back(e);
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_midi_message_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_midi_message_decoder: MIDI message decoder testbench
// Feeds directed and random MIDI byte streams with random gaps and stalls,
// toggles channel mode promotion, and lets the checker score every event.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_midi_message_decoder;
  import mmd_pkg::*;

  localparam int N_RANDOM_MSGS = 345;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_data = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_data = 1'b0;
  int        fail_count, pending_events, event_count;
  int        byte_count = 0;
  bit        calm = 1'b0;
  int        pop_hold = 0;

  midi_message_decoder i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  midi_event_checker i_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_events(pending_events),
    .event_count(event_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the event side in short random bursts.
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else if (calm) pop <= 1'b1;
    else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      pop_hold <= $urandom_range(0, 3);
      pop <= 1'b0;
    end else pop <= 1'b1;
  end

  // Send one byte request, with an optional idle burst first.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= '{byte_value: b, packet_last: last, arrival_time: $urandom};
    @(posedge clk);
    while (full) @(posedge clk);
    byte_count++;
  endtask

  task automatic send_data(int n);
    repeat (n) send_byte(8'($urandom_range(0, 127)), 1'b0);
  endtask

  // Drain all events, then write the promotion register.
  task automatic set_promote(logic v);
    push <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send one random message, mostly well formed.
  task automatic send_message();
    int sel, n;
    logic [7:0] st;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      st = 8'($urandom_range(8'h80, 8'hEF));
      if (sel < 15) st = {4'hB, 4'($urandom)};
      send_byte(st, 1'b0);
      send_byte(sel < 15 ? 8'($urandom_range(112, 127)) : 8'($urandom_range(0, 127)), 1'b0);
      if (st[7:4] != 4'hC && st[7:4] != 4'hD)
        send_byte(sel < 12 ? 8'(7'h7F * $urandom_range(0, 1)) : 8'($urandom_range(0, 127)),
                  $urandom_range(0, 19) == 0);
    end else if (sel < 50) begin
      st = 8'($urandom_range(8'hF1, 8'hF3));
      send_byte(st, 1'b0);
      send_data(st == 8'hF2 ? 2 : 1);
    end else if (sel < 60) begin
      send_byte(8'($urandom_range(8'hF4, 8'hFF)), $urandom_range(0, 9) == 0);
    end else if (sel < 72) begin
      send_byte(ST_SYSEX, 1'b0);
      if ($urandom_range(0, 1)) send_byte(8'($urandom_range(1, 8'h7D)), 1'b0);
      else begin
        send_byte(8'h00, 1'b0);
        send_data(2);
      end
      send_data($urandom_range(0, 5));
      send_byte(ST_EOX, 1'b0);
    end else if (sel < 90) begin
      send_byte(ST_SYSEX, 1'b0);
      n = $urandom_range(0, 3);
      if (n == 0) begin
        send_byte(8'h7E, 1'b0);
        send_data(1);
        send_byte(8'd6, 1'b0);
        send_byte(8'd1, 1'b0);
      end else if (n == 1) begin
        send_byte(8'h7E, 1'b0);
        send_data(1);
        send_byte(8'd6, 1'b0);
        send_byte(8'd2, 1'b0);
        send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 127)), 1'b0);
        send_data($urandom_range(6, 14));
      end else if (n == 2) begin
        send_byte(8'h7F, 1'b0);
        send_data(1);
        send_byte(8'd1, 1'b0);
        send_byte(8'd1, 1'b0);
        send_data($urandom_range(2, 6));
      end else begin
        send_byte($urandom_range(0, 1) ? 8'h7E : 8'h7F, 1'b0);
        send_data($urandom_range(0, 20));
      end
      send_byte(ST_EOX, 1'b0);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    #2000000;
    $display("FAIL midi_message_decoder");
    $finish;
  end

  initial begin
    int i;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: extremes, realtime, errors, a plain and a universal sysex.
    send_byte(8'h05, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0); send_byte(8'h7F, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'hEF, 1'b0); send_byte(8'h7F, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'hB0, 1'b0); send_byte(8'd122, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'hB0, 1'b0); send_byte(8'd126, 1'b0); send_byte(8'd3, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'hF8, 1'b0);
    send_byte(8'hC0, 1'b1);
    send_byte(8'hF0, 1'b0); send_byte(8'h43, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h7E, 1'b0); send_data(20); send_byte(8'hF7, 1'b0);
    set_promote(1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'd127, 1'b0); send_byte(8'h00, 1'b0);
    for (i = 0; i < N_RANDOM_MSGS; i++) begin
      if (i % 100 == 99) set_promote(1'($urandom_range(0, 1)));
      if (i == N_RANDOM_MSGS - 40) calm = 1'b1;
      send_message();
    end
    push <= 1'b0;
    while (pending_events != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes and scored %0d decoded events across promotion settings.",
             byte_count, event_count);
    if (fail_count == 0) begin
      $display("PASS midi_message_decoder");
    end else begin
      $display("FAIL midi_message_decoder");
    end
    $finish;
  end

endmodule

`default_nettype wire
